// ----- design/rmq_pkg.sv -----
package rmq_pkg;

   localparam int A_W     = 17;
   localparam int RAD_W   = 34;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int SQ_W    = 2 * ROOT_W;
   localparam int SUMSQ_W = SQ_W + 2;
   localparam int NORM_W  = SUMSQ_W / 2;
   localparam int Q_W     = 15;
   localparam int QUAT_W  = 16;
   localparam int POS_W   = 32;
   localparam int LANES   = 4;

   localparam int LANE_W = 0;
   localparam int LANE_X = 1;
   localparam int LANE_Y = 2;
   localparam int LANE_Z = 3;

   localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m01;
      logic signed [15:0] m02;
      logic signed [15:0] m10;
      logic signed [15:0] m11;
      logic signed [15:0] m12;
      logic signed [15:0] m20;
      logic signed [15:0] m21;
      logic signed [15:0] m22;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_z;
   } rmq_pose_type;

   typedef struct packed {
      logic [LANES-1:0] neg;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
   } rmq_side_type;

   typedef struct packed {
      rmq_side_type                   side;
      logic [LANES-1:0][ROOT_W-1:0]   root;
   } rmq_norm_tag_type;

endpackage

// ----- design/rmq_if.sv -----
interface rmq_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] m00;
   logic signed [15:0] m01;
   logic signed [15:0] m02;
   logic signed [15:0] m10;
   logic signed [15:0] m11;
   logic signed [15:0] m12;
   logic signed [15:0] m20;
   logic signed [15:0] m21;
   logic signed [15:0] m22;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 pos_x, pos_y, pos_z, output ready);
endinterface

interface rmq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;

   modport source (output valid, out_x, out_y, out_z, quat_w, quat_x, quat_y, quat_z,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, quat_w, quat_x, quat_y, quat_z,
                 output ready);
endinterface

// ----- design/rmq_front.sv -----
module rmq_front import rmq_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  rmq_pose_type                in_pose,
   output logic                        out_valid,
   output logic [LANES-1:0][RAD_W-1:0] out_rad,
   output rmq_side_type                out_side
);

   localparam int D21M12 = 0;
   localparam int D02M20 = 1;
   localparam int D10M01 = 2;
   localparam int S10P01 = 3;
   localparam int S02P20 = 4;
   localparam int S21P12 = 5;

   logic signed [18:0] e00, e11, e22;
   logic signed [18:0] sum_w, sum_x, sum_y, sum_z;
   logic [A_W-1:0]     a_in [LANES];
   logic [5:0]         sgn_in;

   logic               vld1_ff;
   logic [A_W-1:0]     a_ff [LANES];
   logic [5:0]         sgn_ff;
   logic [POS_W-1:0]   px_ff, py_ff, pz_ff;

   logic               w_max, x_max, y_max;
   logic [LANES-1:0]   neg_in;

   logic               vld2_ff;
   logic [LANES-1:0][RAD_W-1:0] rad_ff;
   rmq_side_type       side_ff;

   assign e00 = 19'(in_pose.m00);
   assign e11 = 19'(in_pose.m11);
   assign e22 = 19'(in_pose.m22);
   assign sum_w =  e00 + e11 + e22 + 19'sd16384;
   assign sum_x =  e00 - e11 - e22 + 19'sd16384;
   assign sum_y = -e00 + e11 - e22 + 19'sd16384;
   assign sum_z = -e00 - e11 + e22 + 19'sd16384;

   assign a_in[LANE_W] = sum_w[18] ? '0 : sum_w[A_W-1:0];
   assign a_in[LANE_X] = sum_x[18] ? '0 : sum_x[A_W-1:0];
   assign a_in[LANE_Y] = sum_y[18] ? '0 : sum_y[A_W-1:0];
   assign a_in[LANE_Z] = sum_z[18] ? '0 : sum_z[A_W-1:0];

   always_comb begin
      logic signed [16:0] d;
      d = 17'(in_pose.m21) - 17'(in_pose.m12);
      sgn_in[D21M12] = d[16];
      d = 17'(in_pose.m02) - 17'(in_pose.m20);
      sgn_in[D02M20] = d[16];
      d = 17'(in_pose.m10) - 17'(in_pose.m01);
      sgn_in[D10M01] = d[16];
      d = 17'(in_pose.m10) + 17'(in_pose.m01);
      sgn_in[S10P01] = d[16];
      d = 17'(in_pose.m02) + 17'(in_pose.m20);
      sgn_in[S02P20] = d[16];
      d = 17'(in_pose.m21) + 17'(in_pose.m12);
      sgn_in[S21P12] = d[16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
      end
      if (en) begin
         a_ff   <= a_in;
         sgn_ff <= sgn_in;
         px_ff  <= in_pose.pos_x;
         py_ff  <= in_pose.pos_y;
         pz_ff  <= in_pose.pos_z;
      end
   end

   assign w_max = a_ff[LANE_W] >= a_ff[LANE_X] && a_ff[LANE_W] >= a_ff[LANE_Y] &&
                  a_ff[LANE_W] >= a_ff[LANE_Z];
   assign x_max = a_ff[LANE_X] >= a_ff[LANE_W] && a_ff[LANE_X] >= a_ff[LANE_Y] &&
                  a_ff[LANE_X] >= a_ff[LANE_Z];
   assign y_max = a_ff[LANE_Y] >= a_ff[LANE_W] && a_ff[LANE_Y] >= a_ff[LANE_X] &&
                  a_ff[LANE_Y] >= a_ff[LANE_Z];

   always_comb begin
      neg_in = '0;
      if (w_max) begin
         neg_in[LANE_X] = sgn_ff[D21M12];
         neg_in[LANE_Y] = sgn_ff[D02M20];
         neg_in[LANE_Z] = sgn_ff[D10M01];
      end else if (x_max) begin
         neg_in[LANE_W] = sgn_ff[D21M12];
         neg_in[LANE_Y] = sgn_ff[S10P01];
         neg_in[LANE_Z] = sgn_ff[S02P20];
      end else if (y_max) begin
         neg_in[LANE_W] = sgn_ff[D02M20];
         neg_in[LANE_X] = sgn_ff[S10P01];
         neg_in[LANE_Z] = sgn_ff[S21P12];
      end else begin
         neg_in[LANE_W] = sgn_ff[D10M01];
         neg_in[LANE_X] = sgn_ff[S02P20];
         neg_in[LANE_Y] = sgn_ff[S21P12];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld2_ff <= vld1_ff;
      end
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            rad_ff[l] <= {1'b0, a_ff[l], 16'b0};
         end
         side_ff.neg   <= neg_in;
         side_ff.pos_x <= px_ff;
         side_ff.pos_y <= py_ff;
         side_ff.pos_z <= pz_ff;
      end
   end

   assign out_valid = vld2_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;

endmodule

// ----- design/rmq_sqrt.sv -----
module rmq_sqrt #(
   parameter int IN_W  = 34,
   parameter int LANES = 4,
   parameter int TAG_W = 1,
   localparam int RW   = IN_W / 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [LANES-1:0][IN_W-1:0] in_rad,
   input  logic [TAG_W-1:0]         in_tag,
   output logic                     out_valid,
   output logic [LANES-1:0][RW-1:0] out_root,
   output logic [TAG_W-1:0]         out_tag
);

   logic            vld_ff [RW];
   logic [RW+1:0]   rem_ff [RW][LANES];
   logic [RW-1:0]   root_ff [RW][LANES];
   logic [IN_W-1:0] rad_ff [RW][LANES];
   logic [TAG_W-1:0] tag_ff [RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic            vld_p;
      logic [RW+1:0]   rem_p [LANES];
      logic [RW-1:0]   root_p [LANES];
      logic [IN_W-1:0] rad_p [LANES];
      logic [TAG_W-1:0] tag_p;
      logic [RW+1:0]   rem_in [LANES];
      logic [RW-1:0]   root_in [LANES];
      logic [IN_W-1:0] rad_in [LANES];

      if (s == 0) begin : g_first
         assign vld_p = in_valid;
         assign tag_p = in_tag;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_p[l]  = '0;
            assign root_p[l] = '0;
            assign rad_p[l]  = in_rad[l];
         end
      end else begin : g_next
         assign vld_p  = vld_ff[s-1];
         assign tag_p  = tag_ff[s-1];
         assign rem_p  = rem_ff[s-1];
         assign root_p = root_ff[s-1];
         assign rad_p  = rad_ff[s-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane_op
         logic [RW+3:0] cat, trial;
         logic          ge;
         assign cat   = {rem_p[l], rad_p[l][IN_W-1 -: 2]};
         assign trial = {2'b00, root_p[l], 2'b01};
         assign ge    = cat >= trial;
         assign rem_in[l]  = ge ? (RW+2)'(cat - trial) : cat[RW+1:0];
         assign root_in[l] = {root_p[l][RW-2:0], ge};
         assign rad_in[l]  = {rad_p[l][IN_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_p;
         end
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            rad_ff[s]  <= rad_in;
            tag_ff[s]  <= tag_p;
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_root[l] = root_ff[RW-1][l];
   end
   assign out_valid = vld_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule

// ----- design/rmq_div.sv -----
module rmq_div import rmq_pkg::*; #(
   parameter int TAG_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [LANES-1:0][ROOT_W-1:0] in_root,
   input  logic [NORM_W-1:0]            in_norm,
   input  logic [TAG_W-1:0]             in_tag,
   output logic                         out_valid,
   output logic [LANES-1:0][Q_W-1:0]    out_quo,
   output logic                         out_zero,
   output logic [TAG_W-1:0]             out_tag
);

   localparam int D_W = NORM_W + 1;
   localparam int N_W = ROOT_W + Q_W + 1;

   logic             vld_ff [Q_W];
   logic [D_W-1:0]   d_ff [Q_W];
   logic [D_W-1:0]   r_ff [Q_W][LANES];
   logic [Q_W-1:0]   low_ff [Q_W][LANES];
   logic [Q_W-1:0]   q_ff [Q_W][LANES];
   logic [TAG_W-1:0] tag_ff [Q_W];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      logic             vld_p;
      logic [D_W-1:0]   d_p;
      logic [D_W-1:0]   r_p [LANES];
      logic [Q_W-1:0]   low_p [LANES];
      logic [Q_W-1:0]   q_p [LANES];
      logic [TAG_W-1:0] tag_p;
      logic [D_W-1:0]   r_in [LANES];
      logic [Q_W-1:0]   low_in [LANES];
      logic [Q_W-1:0]   q_in [LANES];

      if (s == 0) begin : g_first
         assign vld_p = in_valid;
         assign d_p   = {in_norm, 1'b0};
         assign tag_p = in_tag;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [N_W-1:0] num;
            assign num      = N_W'({in_root[l], {Q_W{1'b0}}}) + N_W'(in_norm);
            assign r_p[l]   = D_W'(num[N_W-1:Q_W]);
            assign low_p[l] = num[Q_W-1:0];
            assign q_p[l]   = '0;
         end
      end else begin : g_next
         assign vld_p = vld_ff[s-1];
         assign d_p   = d_ff[s-1];
         assign tag_p = tag_ff[s-1];
         assign r_p   = r_ff[s-1];
         assign low_p = low_ff[s-1];
         assign q_p   = q_ff[s-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane_op
         logic [D_W:0] cat;
         logic         ge;
         assign cat       = {r_p[l], low_p[l][Q_W-1]};
         assign ge        = cat >= {1'b0, d_p};
         assign r_in[l]   = ge ? D_W'(cat - {1'b0, d_p}) : cat[D_W-1:0];
         assign low_in[l] = {low_p[l][Q_W-2:0], 1'b0};
         assign q_in[l]   = {q_p[l][Q_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_p;
         end
         if (en) begin
            d_ff[s]   <= d_p;
            r_ff[s]   <= r_in;
            low_ff[s] <= low_in;
            q_ff[s]   <= q_in;
            tag_ff[s] <= tag_p;
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_quo[l] = q_ff[Q_W-1][l];
   end
   assign out_valid = vld_ff[Q_W-1];
   assign out_zero  = d_ff[Q_W-1] == '0;
   assign out_tag   = tag_ff[Q_W-1];

endmodule

// ----- design/rotation_matrix_to_quaternion_core.sv -----
// Converts a Q2.14 rotation matrix to a Q1.14 unit quaternion and passes the Q16.16
// translation through. The pipeline takes one pose per cycle while the result side
// does not stall it. A pose passes in order through quarter-sums and sign selection,
// the four component roots, squaring and summing, the norm root, the four dividers,
// and then saturation, zero forcing and sign in the output register. A beat that
// waits on the result side holds the whole pipeline, so the request side is ready
// exactly when the output register is empty or being taken.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
   input logic        clock,
   input logic        reset,
   rmq_req_if.sink    req_ch,
   rmq_rsp_if.source  rsp_ch
);

   logic                         en;
   rmq_pose_type                 pose;

   logic                         fr_valid;
   logic [LANES-1:0][RAD_W-1:0]  fr_rad;
   rmq_side_type                 fr_side;

   logic                         rt_valid;
   logic [LANES-1:0][ROOT_W-1:0] rt_root;
   rmq_side_type                 rt_side;

   logic                         sq_vld_ff;
   logic [SQ_W-1:0]              sq_ff [LANES];
   rmq_norm_tag_type             sq_tag_ff;

   logic                         sum_vld_ff;
   logic [0:0][SUMSQ_W-1:0]      sum_ff;
   rmq_norm_tag_type             sum_tag_ff;

   logic                         nm_valid;
   logic [0:0][NORM_W-1:0]       nm_norm;
   rmq_norm_tag_type             nm_tag;

   logic                         dv_valid;
   logic [LANES-1:0][Q_W-1:0]    dv_quo;
   logic                         dv_zero;
   rmq_side_type                 dv_side;

   logic                         out_vld_ff;
   logic [QUAT_W-1:0]            quat_ff [LANES];
   rmq_side_type                 out_side_ff;
   logic [QUAT_W-1:0]            quat_in [LANES];

   assign en = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   assign pose.m00   = req_ch.m00;
   assign pose.m01   = req_ch.m01;
   assign pose.m02   = req_ch.m02;
   assign pose.m10   = req_ch.m10;
   assign pose.m11   = req_ch.m11;
   assign pose.m12   = req_ch.m12;
   assign pose.m20   = req_ch.m20;
   assign pose.m21   = req_ch.m21;
   assign pose.m22   = req_ch.m22;
   assign pose.pos_x = req_ch.pos_x;
   assign pose.pos_y = req_ch.pos_y;
   assign pose.pos_z = req_ch.pos_z;

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_pose   (pose),
      .out_valid (fr_valid),
      .out_rad   (fr_rad),
      .out_side  (fr_side)
   );

   rmq_sqrt #(
      .IN_W  (RAD_W),
      .LANES (LANES),
      .TAG_W ($bits(rmq_side_type))
   ) u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_tag    (fr_side),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_tag   (rt_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else if (en) begin
         sq_vld_ff  <= rt_valid;
         sum_vld_ff <= sq_vld_ff;
      end
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            sq_ff[l] <= SQ_W'(rt_root[l]) * SQ_W'(rt_root[l]);
         end
         sq_tag_ff.side <= rt_side;
         sq_tag_ff.root <= rt_root;
         sum_ff[0] <= SUMSQ_W'(sq_ff[LANE_W]) + SUMSQ_W'(sq_ff[LANE_X]) +
                      SUMSQ_W'(sq_ff[LANE_Y]) + SUMSQ_W'(sq_ff[LANE_Z]);
         sum_tag_ff <= sq_tag_ff;
      end
   end

   rmq_sqrt #(
      .IN_W  (SUMSQ_W),
      .LANES (1),
      .TAG_W ($bits(rmq_norm_tag_type))
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sum_vld_ff),
      .in_rad    (sum_ff),
      .in_tag    (sum_tag_ff),
      .out_valid (nm_valid),
      .out_root  (nm_norm),
      .out_tag   (nm_tag)
   );

   rmq_div #(
      .TAG_W ($bits(rmq_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nm_valid),
      .in_root   (nm_tag.root),
      .in_norm   (nm_norm[0]),
      .in_tag    (nm_tag.side),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_zero  (dv_zero),
      .out_tag   (dv_side)
   );

   always_comb begin
      logic [Q_W-1:0] mag;
      for (int l = 0; l < LANES; l++) begin
         mag = dv_zero ? '0 : (dv_quo[l] > ONE_Q14 ? ONE_Q14 : dv_quo[l]);
         quat_in[l] = dv_side.neg[l] ? QUAT_W'(-QUAT_W'(mag)) : QUAT_W'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= dv_valid;
      end
      if (en) begin
         quat_ff     <= quat_in;
         out_side_ff <= dv_side;
      end
   end

   assign rsp_ch.valid  = out_vld_ff;
   assign rsp_ch.out_x  = out_side_ff.pos_x;
   assign rsp_ch.out_y  = out_side_ff.pos_y;
   assign rsp_ch.out_z  = out_side_ff.pos_z;
   assign rsp_ch.quat_w = quat_ff[LANE_W];
   assign rsp_ch.quat_x = quat_ff[LANE_X];
   assign rsp_ch.quat_y = quat_ff[LANE_Y];
   assign rsp_ch.quat_z = quat_ff[LANE_Z];

`ifndef NO_ASSERTIONS
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready == (!rsp_ch.valid || rsp_ch.ready))
      else $error("request ready does not follow the output register");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result beat valid right after reset");

   a_quat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.quat_w >= -16'sd16384 && rsp_ch.quat_w <= 16'sd16384 &&
                        rsp_ch.quat_x >= -16'sd16384 && rsp_ch.quat_x <= 16'sd16384 &&
                        rsp_ch.quat_y >= -16'sd16384 && rsp_ch.quat_y <= 16'sd16384 &&
                        rsp_ch.quat_z >= -16'sd16384 && rsp_ch.quat_z <= 16'sd16384))
      else $error("quaternion component out of range");

   a_quat_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.quat_w != '0 || rsp_ch.quat_x != '0 ||
                        rsp_ch.quat_y != '0 || rsp_ch.quat_z != '0))
      else $error("quaternion is all zero");
`endif

endmodule
